// File: design/crs_pkg.sv
// ============================================================================
// crs_pkg
// Shared constants and types for the circle rasterizer (direct square root,
// eight-way symmetry).
// ============================================================================
package crs_pkg;

    // Action codes of an input beat
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // Colour field width (fixed 0x00BBGGRR)
    localparam int COLOR_W = 24;

    // Points per step and the width of their index
    localparam int NUM_PTS   = 8;
    localparam int PT_IDX_W  = $clog2(NUM_PTS);

    // Handoff of one finished step from the sequencer to the emitter
    typedef struct packed {
        logic valid;       // step values are ready to be taken
        logic final_step;  // this step closes the circle
    } t_step_ctl;

endpackage

// File: design/crs_if.sv
// ============================================================================
// crs_if
// Valid/ready channel interfaces: the command channel into the rasterizer
// and the pixel channel out of it.
// ============================================================================
interface crs_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
    logic [23:0]           draw_color;

    modport source (
        output valid, action, center_x, center_y, radius, draw_color,
        input  ready
    );
    modport sink (
        input  valid, action, center_x, center_y, radius, draw_color,
        output ready
    );
endinterface

interface crs_out_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic [23:0]                  pixel_color;
    logic                         last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last,
        output ready
    );
endinterface

// File: design/crs_sqrt.sv
// ============================================================================
// crs_sqrt
// Bit-serial rounded integer square root. The radicand shifts out two bits a
// cycle into a narrow remainder; one root bit is settled per cycle, then a
// final step rounds the root up when the remainder exceeds it.
// ============================================================================
module crs_sqrt #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*COORD_BITS-1:0]   i_radicand,
    output logic                      o_done,
    output logic [COORD_BITS-1:0]     o_root
);

    localparam int RAD_W = 2 * COORD_BITS;
    localparam int REM_W = COORD_BITS + 1;
    localparam int CUR_W = COORD_BITS + 2;
    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [COORD_BITS-1:0] r_root;

    logic [CUR_W-1:0]      w_cur;
    logic [CUR_W-1:0]      w_trial;
    logic [CUR_W-1:0]      w_diff;
    logic                  w_ge;
    logic                  w_round_up;

    // One restoring step: bring in the next radicand digit, try root*4+1
    assign w_cur      = {r_rem[COORD_BITS-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial    = {r_root, 2'b01};
    assign w_ge       = (w_cur >= w_trial);
    assign w_diff     = w_cur - w_trial;
    assign w_round_up = (r_rem > {1'b0, r_root});

    // Iteration and rounding sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(COORD_BITS)) begin
                    // remainder above the floor root: round up
                    r_root <= r_root + COORD_BITS'(w_round_up);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
                    r_root <= {r_root[COORD_BITS-2:0], w_ge};
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: design/crs_emit.sv
// ============================================================================
// crs_emit
// Eight-way point emitter. Holds a copy of one step (center, offsets, colour)
// and sends its eight symmetric points through an output register, one beat a
// cycle unless stalled. A new step is taken when idle or with the last point.
// ============================================================================
module crs_emit #(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crs_pkg::t_step_ctl            i_hand,
    output logic                          o_take_ready,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    input  logic [COORD_BITS-1:0]         i_x,
    input  logic [COORD_BITS-1:0]         i_y,
    input  logic [crs_pkg::COLOR_W-1:0]   i_color,
    crs_out_if.source                     o_pix
);

    import crs_pkg::*;

    localparam int OW = COORD_BITS + 2;

    logic                  r_act;
    logic [PT_IDX_W-1:0]   r_k;
    logic                  r_fin;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [COLOR_W-1:0]    r_col;

    logic                  r_ov;
    logic [OW-1:0]         r_px;
    logic [OW-1:0]         r_py;
    logic [COLOR_W-1:0]    r_pc;
    logic                  r_last;

    logic                  w_adv;
    logic                  w_take;
    logic                  w_end;
    logic [OW-1:0]         w_a;
    logic [OW-1:0]         w_b;
    logic [OW-1:0]         w_px;
    logic [OW-1:0]         w_py;

    assign w_adv        = r_act && (!r_ov || o_pix.ready);
    assign w_end        = (r_k == PT_IDX_W'(NUM_PTS - 1));
    assign o_take_ready = !r_act || (w_adv && w_end);
    assign w_take       = i_hand.valid && o_take_ready;

    // Point k: bit 2 swaps the offsets, bit 1 negates column, bit 0 row
    assign w_a  = r_k[2] ? {2'b00, r_y} : {2'b00, r_x};
    assign w_b  = r_k[2] ? {2'b00, r_x} : {2'b00, r_y};
    assign w_px = r_k[1] ? ({2'b00, r_cx} - w_a) : ({2'b00, r_cx} + w_a);
    assign w_py = r_k[0] ? ({2'b00, r_cy} - w_b) : ({2'b00, r_cy} + w_b);

    // Step copy, point counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ov   <= 1'b1;
                r_px   <= w_px;
                r_py   <= w_py;
                r_pc   <= r_col;
                r_last <= r_fin && w_end;
            end else if (o_pix.ready) begin
                r_ov <= 1'b0;
            end
            if (w_take) begin
                r_act <= 1'b1;
                r_k   <= '0;
                r_fin <= i_hand.final_step;
                r_cx  <= i_cx;
                r_cy  <= i_cy;
                r_x   <= i_x;
                r_y   <= i_y;
                r_col <= i_color;
            end else if (w_adv) begin
                r_k <= r_k + 1'b1;
                if (w_end) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    assign o_pix.valid       = r_ov;
    assign o_pix.pixel_x     = $signed(r_px);
    assign o_pix.pixel_y     = $signed(r_py);
    assign o_pix.pixel_color = r_pc;
    assign o_pix.last        = r_last;

endmodule

// File: design/circle_raster_sqrt_octant.sv
// ============================================================================
// circle_raster_sqrt_octant
// Circle rasterizer, direct square-root method with eight-way symmetry.
// ============================================================================
// Usage:
//   i_in carries commands. A start beat (action = 0) loads center, radius and
//   colour and yields the eight points of x = 0, y = R. An advance beat
//   (action = 1) moves x up by one, sets y to the rounded root of R*R - x*x
//   and yields eight points. An advance with no circle running is accepted
//   and yields nothing. The circle ends on the step where x is no longer
//   below y; its eighth point carries last.
//   o_pix carries one point per beat, eight per step, duplicates kept.
// Timing:
//   A start step is offered to the emitter in the cycle after acceptance;
//   an advance step waits for the bit-serial root unit, which settles one
//   root bit per cycle and then rounds. The emitter first stores the step,
//   then loads its first point into the output register. Emission of one
//   step overlaps the root of the next, so the next command can be taken
//   while the points of the previous step are still going out.
// Reset and stalls:
//   Reset leaves no circle running and both channels empty. When the receiver
//   stalls, the output register holds its beat; i_in takes the next command
//   as soon as the previous step has been handed to the emitter.
// ============================================================================
module circle_raster_sqrt_octant #(
    parameter int COORD_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crs_in_if.sink     i_in,
    crs_out_if.source  o_pix
);

    import crs_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_HAND
    } t_state;

    t_state                r_state;
    logic                  r_busy;
    logic                  r_fin;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [COLOR_W-1:0]    r_col;
    logic [SQ_W-1:0]       r_sq;

    logic                  w_acc;
    logic                  w_adv_go;
    logic [COORD_BITS-1:0] w_x_inc;
    logic [SQ_W-1:0]       w_sq_next;
    logic [SQ_W-1:0]       w_rsq;
    logic                  w_root_done;
    logic [COORD_BITS-1:0] w_root;
    logic                  w_take_ready;
    t_step_ctl             w_hand;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_adv_go   = w_acc && (i_in.action == ACT_ADVANCE) && r_busy;

    // R*R - x*x kept by running difference: (x+1)^2 - x^2 = 2x + 1
    assign w_x_inc   = r_x + 1'b1;
    assign w_sq_next = r_sq - {{(COORD_BITS - 1){1'b0}}, r_x, 1'b1};
    assign w_rsq     = SQ_W'(i_in.radius) * SQ_W'(i_in.radius);

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_in.action == ACT_START) begin
                            r_cx    <= i_in.center_x;
                            r_cy    <= i_in.center_y;
                            r_col   <= i_in.draw_color;
                            r_x     <= '0;
                            r_y     <= i_in.radius;
                            r_sq    <= w_rsq;
                            r_fin   <= (i_in.radius == '0);
                            r_busy  <= (i_in.radius != '0);
                            r_state <= S_HAND;
                        end else if (r_busy) begin
                            r_x     <= w_x_inc;
                            r_sq    <= w_sq_next;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    if (w_root_done) begin
                        r_y     <= w_root;
                        r_fin   <= !(r_x < w_root);
                        r_busy  <= (r_x < w_root);
                        r_state <= S_HAND;
                    end
                end
                S_HAND: begin
                    if (w_take_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_hand.valid      = (r_state == S_HAND);
    assign w_hand.final_step = r_fin;

    crs_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_adv_go),
        .i_radicand (w_sq_next),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    crs_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hand       (w_hand),
        .o_take_ready (w_take_ready),
        .i_cx         (r_cx),
        .i_cy         (r_cy),
        .i_x          (r_x),
        .i_y          (r_y),
        .i_color      (r_col),
        .o_pix        (o_pix)
    );

endmodule

// File: bench/tb_circle_raster_sqrt_octant.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_circle_raster_sqrt_octant
// Self-checking bench for the square-root circle rasterizer. A queue of
// start/advance commands feeds a clocked driver. Each accepted command is run
// through a local octant model that predicts the eight pixels of a step, if any.
// A clocked monitor compares every pixel beat, field by field, with the
// oldest prediction. Both channels idle in random bursts, except in the
// final part of the run.
// ============================================================================
module tb_circle_raster_sqrt_octant;
    import crs_pkg::*;

    localparam int CB = 12;
    localparam int OW = CB + 2;

    typedef struct {
        logic          action;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-1:0] rad;
        logic [23:0]   color;
        bit            drain;   // hold this beat until every pixel is back
    } t_cmd;

    typedef struct {
        logic [OW-1:0] px;
        logic [OW-1:0] py;
        logic [23:0]   color;
        logic          last;
    } t_pix;

    logic i_clk;
    logic i_rst_n;

    crs_in_if  #(.COORD_BITS(CB)) in_if ();
    crs_out_if #(.COORD_BITS(CB)) pix_if ();

    circle_raster_sqrt_octant #(
        .COORD_BITS (CB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_pix   (pix_if)
    );

    // Commands waiting to be driven and pixels waiting to be seen
    t_cmd pending[$];
    t_pix pix_expected[$];

    int   stim_total;
    int   beats_taken;
    int   mismatches;
    logic quiet;

    // Octant model state
    bit            circ_busy;
    logic [CB-1:0] circ_x;
    logic [CB-1:0] circ_y;
    logic [CB-1:0] circ_rad;
    logic [CB-1:0] circ_cx;
    logic [CB-1:0] circ_cy;
    logic [23:0]   circ_color;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Rounded integer square root: floor root, plus one when the remainder
    // exceeds it
    // ------------------------------------------------------------------------
    function automatic int unsigned round_root(input int unsigned n);
        int unsigned root;
        int unsigned cand;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            cand = root | (32'd1 << b);
            if (cand * cand <= n) root = cand;
        end
        if (n - root * root > root) root = root + 1;
        return root;
    endfunction

    // Number of advance beats until x catches up with y
    function automatic int advances_to_close(input int unsigned rad);
        int unsigned x;
        int unsigned y;
        int          cnt;
        x   = 0;
        y   = rad;
        cnt = 0;
        while (x < y) begin
            x   = x + 1;
            y   = round_root(rad * rad - x * x);
            cnt = cnt + 1;
        end
        return cnt;
    endfunction

    // ------------------------------------------------------------------------
    // Predict the pixels of one accepted command
    // ------------------------------------------------------------------------
    task automatic plot_octants(input t_cmd c);
        logic [OW-1:0] cx;
        logic [OW-1:0] cy;
        logic [OW-1:0] x;
        logic [OW-1:0] y;
        logic          done;
        logic [OW-1:0] xs[8];
        logic [OW-1:0] ys[8];
        t_pix          p;
        if (c.action == ACT_START) begin
            circ_cx    = c.cx;
            circ_cy    = c.cy;
            circ_rad   = c.rad;
            circ_color = c.color;
            circ_x     = '0;
            circ_y     = c.rad;
        end else begin
            // advance with no circle running is dropped
            if (!circ_busy) return;
            circ_x = circ_x + 1'b1;
            circ_y = CB'(round_root(int'(circ_rad) * int'(circ_rad)
                                    - int'(circ_x) * int'(circ_x)));
        end
        done      = !(circ_x < circ_y);
        circ_busy = !done;

        cx = {2'b00, circ_cx};
        cy = {2'b00, circ_cy};
        x  = {2'b00, circ_x};
        y  = {2'b00, circ_y};
        xs = '{cx + x, cx + x, cx - x, cx - x, cx + y, cx + y, cx - y, cx - y};
        ys = '{cy + y, cy - y, cy + y, cy - y, cy + x, cy - x, cy + x, cy - x};
        for (int k = 0; k < NUM_PTS; k++) begin
            p.px    = xs[k];
            p.py    = ys[k];
            p.color = circ_color;
            p.last  = (k == NUM_PTS - 1) ? done : 1'b0;
            pix_expected.push_back(p);
        end
    endtask

    // ------------------------------------------------------------------------
    // Compare one pixel beat with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_pixel(input t_pix got);
        t_pix exp_pix;
        if (pix_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                         $realtime, $signed(got.px), $signed(got.py), got.color,
                         got.last);
            return;
        end
        exp_pix = pix_expected.pop_front();
        if (got.px !== exp_pix.px || got.py !== exp_pix.py ||
            got.color !== exp_pix.color || got.last !== exp_pix.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] pixel mismatch exp x=%0d y=%0d color=%06h last=%0b",
                         $realtime, $signed(exp_pix.px), $signed(exp_pix.py),
                         exp_pix.color, exp_pix.last,
                         " got x=%0d y=%0d color=%06h last=%0b",
                         $signed(got.px), $signed(got.py), got.color, got.last);
        end
    endtask

    task automatic add_cmd(input logic act, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-1:0] rad,
                           input logic [23:0] color, input bit drain);
        t_cmd c;
        c.action = act;
        c.cx     = cx;
        c.cy     = cy;
        c.rad    = rad;
        c.color  = color;
        c.drain  = drain;
        pending.push_back(c);
    endtask

    task automatic add_advance();
        add_cmd(ACT_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom),
                24'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: one command beat at a time from the pending queue
    // ------------------------------------------------------------------------
    t_cmd cur_cmd;
    int   gap_left;
    int   tx_mode;
    int   tx_sent;

    always @(posedge i_clk) begin
        logic fire;
        logic vld;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            quiet       <= 1'b0;
            gap_left    = 0;
            tx_mode     = 0;
            tx_sent     = 0;
        end else begin
            fire = in_if.valid && in_if.ready;
            if (fire) begin
                plot_octants(cur_cmd);
                beats_taken++;
            end
            vld = in_if.valid && !fire;
            if (!vld) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0 &&
                             !(pending[0].drain && pix_expected.size() > 0)) begin
                    cur_cmd = pending.pop_front();
                    in_if.action     <= cur_cmd.action;
                    in_if.center_x   <= cur_cmd.cx;
                    in_if.center_y   <= cur_cmd.cy;
                    in_if.radius     <= cur_cmd.rad;
                    in_if.draw_color <= cur_cmd.color;
                    vld = 1'b1;
                    tx_sent++;
                    if (tx_sent % 25 == 0) tx_mode = $urandom_range(0, 2);
                    // idle burst after this beat, none near the end
                    if (pending.size() >= 30 && tx_mode != 0 &&
                        $urandom_range(0, (tx_mode == 2) ? 2 : 6) == 0)
                        gap_left = $urandom_range(1, 19);
                end
            end
            in_if.valid <= vld;
            quiet       <= (pending.size() < 30);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check pixel beats, stall the pixel channel in bursts
    // ------------------------------------------------------------------------
    int stall_left;
    int rx_mode;
    int rx_cycles;

    always @(posedge i_clk) begin
        t_pix got;
        logic rdy;
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
            stall_left   = 0;
            rx_mode      = 0;
            rx_cycles    = 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                got.px    = pix_if.pixel_x;
                got.py    = pix_if.pixel_y;
                got.color = pix_if.pixel_color;
                got.last  = pix_if.last;
                check_pixel(got);
            end
            rx_cycles++;
            if (rx_cycles % 50 == 0) rx_mode = $urandom_range(0, 2);
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!quiet && rx_mode != 0 &&
                         $urandom_range(0, (rx_mode == 2) ? 3 : 9) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            pix_if.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int          counted;
        int          next_drain;
        int          full;
        int          n;
        int unsigned rad;

        in_if.valid      = 1'b0;
        in_if.action     = ACT_START;
        in_if.center_x   = '0;
        in_if.center_y   = '0;
        in_if.radius     = '0;
        in_if.draw_color = '0;
        pix_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        beats_taken      = 0;
        mismatches       = 0;
        circ_busy        = 1'b0;
        circ_x           = '0;
        circ_y           = '0;
        circ_rad         = '0;
        circ_cx          = '0;
        circ_cy          = '0;
        circ_color       = '0;

        // Directed: advance while idle, zero radius at both corners
        add_cmd(ACT_ADVANCE, '1, '1, '1, '1, 1'b0);
        add_cmd(ACT_START, '0, '0, '0, 24'h000000, 1'b0);
        add_cmd(ACT_START, '1, '1, '0, 24'hFFFFFF, 1'b0);
        // radius one: closes on the first advance, the next one is dropped
        add_cmd(ACT_START, 12'd100, 12'd200, 12'd1, 24'h123456, 1'b0);
        add_cmd(ACT_ADVANCE, '0, '0, '0, '0, 1'b0);
        add_cmd(ACT_ADVANCE, '0, '0, '0, '0, 1'b0);
        // largest radius at the edges: coordinates go below zero and past 4095
        add_cmd(ACT_START, 12'd0, 12'd4095, 12'd4095, 24'hFFFFFF, 1'b0);
        repeat (3) add_advance();
        // restart while busy abandons the running circle
        add_cmd(ACT_START, 12'd4095, 12'd0, 12'd4095, 24'hA5A5A5, 1'b0);
        repeat (2) add_advance();
        add_cmd(ACT_START, 12'd2048, 12'd2048, 12'd5, 24'h5A5A5A, 1'b0);
        repeat (advances_to_close(5)) add_advance();
        add_cmd(ACT_START, 12'd1, 12'd1, 12'd2, 24'h00FF00, 1'b0);
        repeat (advances_to_close(2)) add_advance();

        // Random: mostly whole small circles, some large partial ones,
        // some cut short, some dropped advances after the end
        counted    = 0;
        next_drain = 0;
        while (counted < 190) begin
            if ($urandom_range(0, 9) == 0) rad = $urandom_range(25, 4095);
            else                            rad = $urandom_range(0, 24);
            add_cmd(ACT_START, CB'($urandom), CB'($urandom), CB'(rad),
                    24'($urandom), counted >= next_drain);
            if (counted >= next_drain) next_drain += 70;
            counted++;
            full = advances_to_close(rad);
            if (rad > 24)
                n = $urandom_range(1, 5);
            else if (full > 0 && $urandom_range(0, 5) == 0)
                n = $urandom_range(0, full - 1);
            else
                n = full;
            repeat (n) add_advance();
            counted += n;
            if (n == full && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) add_advance();
        end
        stim_total = pending.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < stim_total) @(posedge i_clk);
        while (pix_expected.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (mismatches == 0 && pix_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
